// ----- sv/ita_pkg.sv -----
// shared types and constants for the integer to decimal ascii converter
// depends on nothing; imported by every module of the block
`default_nettype none

package ita_pkg;

    // datapath widths
    localparam int BIN_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = 5;
    localparam int DIG_CNT_W  = 4;
    localparam int CHAR_W     = 6;

    // ascii codes, truncated to the character width
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // microcode addressing
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD   = 3'd0;
    localparam step_t STEP_DABBLE = 3'd1;
    localparam step_t STEP_SKIP   = 3'd2;
    localparam step_t STEP_SIGN   = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;
    localparam step_t STEP_DONE   = 3'd5;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DABBLE,
        OP_SKIP,
        OP_SIGN,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_MORE
    } jmp_t;

    // one control word of the program
    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } ctrl_word_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic hold;
        logic more;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/ita_ucode_rom.sv -----
// microcode program of the converter: one control word per step
// depends on ita_pkg
`default_nettype none

module ita_ucode_rom (
    input  wire  ita_pkg::step_t      step,
    output ita_pkg::ctrl_word_t       ctrl
);
    import ita_pkg::*;

    // program: load, binary to bcd, strip leading zeros, sign, digits
    always_comb
    begin
        case (step)
            STEP_LOAD:   ctrl = '{op: OP_LOAD,   jmp: JMP_NEXT,    target: STEP_LOAD};
            STEP_DABBLE: ctrl = '{op: OP_DABBLE, jmp: JMP_IF_MORE, target: STEP_DABBLE};
            STEP_SKIP:   ctrl = '{op: OP_SKIP,   jmp: JMP_IF_MORE, target: STEP_SKIP};
            STEP_SIGN:   ctrl = '{op: OP_SIGN,   jmp: JMP_NEXT,    target: STEP_LOAD};
            STEP_EMIT:   ctrl = '{op: OP_EMIT,   jmp: JMP_IF_MORE, target: STEP_EMIT};
            STEP_DONE:   ctrl = '{op: OP_NOP,    jmp: JMP_ALWAYS,  target: STEP_LOAD};
            default:     ctrl = '{op: OP_NOP,    jmp: JMP_ALWAYS,  target: STEP_LOAD};
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ita_sequencer.sv -----
// step counter with conditional jumps for the converter microcode
// depends on ita_pkg
`default_nettype none

module ita_sequencer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  ita_pkg::ctrl_word_t ctrl,
    input  wire  ita_pkg::status_t    status,
    output ita_pkg::step_t       step
);
    import ita_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    // jump decision from the control word and datapath status
    always_comb
    begin
        case (ctrl.jmp)
            JMP_ALWAYS:  take_jump = 1'b1;
            JMP_IF_MORE: take_jump = status.more;
            default:     take_jump = 1'b0;
        endcase

        if (status.hold)
            step_next = step_reg;
        else if (take_jump)
            step_next = ctrl.target;
        else
            step_next = step_reg + step_t'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_LOAD;
        else
            step_reg <= step_next;
    end

    assign step = step_reg;

`ifndef SYNTHESIS
    // a held step stays where it is
    a_hold_keeps_step: assert property (@(posedge clk) disable iff (!rst_n)
        status.hold |=> $stable(step_reg))
        else $error("step moved while held");

    // the program never runs past its last step
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_DONE)
        else $error("step outside program");
`endif

endmodule

`default_nettype wire

// ----- sv/ita_datapath.sv -----
// datapath of the converter: shift-and-add-3 bcd unit, digit shifter,
// sign flag and output register; depends on ita_pkg
`default_nettype none

module ita_datapath (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire  ita_pkg::ctrl_word_t  ctrl,
    output ita_pkg::status_t           status,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  signed [31:0]         value,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic [5:0]                 character,
    output logic                       last
);
    import ita_pkg::*;

    logic [BIN_W-1:0]     bin_reg;
    logic [BIN_W-1:0]     bin_next;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    char_reg;
    logic [CHAR_W-1:0]    char_next;
    logic                 last_reg;
    logic                 last_next;

    logic [BIN_W-1:0]     raw;
    logic [BIN_W-1:0]     mag;
    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 lead_zero;
    logic                 out_free;
    logic                 emit;

    assign raw       = value;
    assign mag       = raw[BIN_W-1] ? (BIN_W'(0) - raw) : raw;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign lead_zero = (top_digit == '0) && (dig_cnt_reg != DIG_CNT_W'(1));
    assign out_free  = !out_valid_reg || !out_stall;

    // add 3 to every bcd digit of five or more before the shift
    always_comb
    begin
        logic [DIGIT_W-1:0] nib;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            nib = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    // status to the sequencer
    always_comb
    begin
        status.hold = 1'b0;
        status.more = 1'b0;
        case (ctrl.op)
            OP_LOAD:   status.hold = !in_valid;
            OP_DABBLE: status.more = (bit_cnt_reg != {BIT_CNT_W{1'b1}});
            OP_SKIP:   status.more = lead_zero;
            OP_SIGN:   status.hold = neg_reg && !out_free;
            OP_EMIT:
            begin
                status.hold = !out_free;
                status.more = (dig_cnt_reg != DIG_CNT_W'(1));
            end
            default:
            begin
                status.hold = 1'b0;
                status.more = 1'b0;
            end
        endcase
    end

    assign in_stall = (ctrl.op != OP_LOAD);
    assign emit     = out_free && ((ctrl.op == OP_EMIT) || (ctrl.op == OP_SIGN && neg_reg));

    // next values of the working registers
    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        char_next    = char_reg;
        last_next    = last_reg;

        case (ctrl.op)
            OP_LOAD:
            begin
                bin_next     = mag;
                bcd_next     = '0;
                neg_next     = raw[BIN_W-1];
                bit_cnt_next = '0;
                dig_cnt_next = DIG_CNT_W'(BCD_DIGITS);
            end
            OP_DABBLE:
            begin
                {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
                bit_cnt_next         = bit_cnt_reg + BIT_CNT_W'(1);
            end
            OP_SKIP:
            begin
                if (lead_zero)
                begin
                    bcd_next     = bcd_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            OP_SIGN:
            begin
                if (emit)
                begin
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                end
            end
            OP_EMIT:
            begin
                if (emit)
                begin
                    char_next    = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next    = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next     = bcd_reg << DIGIT_W;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase

        // output slot: filled by a character, emptied by a transaction
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // a new character appears only from a sign or digit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(ctrl.op) == OP_EMIT || $past(ctrl.op) == OP_SIGN))
        else $error("character produced outside an emit step");

    // digit emission always has at least one digit left
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT) |-> (dig_cnt_reg != '0))
        else $error("emit with no digits left");

    // the minus sign never closes a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (char_reg != CHAR_MINUS))
        else $error("minus sign flagged as last");
`endif

endmodule

`default_nettype wire

// ----- sv/int_to_decimal_ascii.sv -----
// int_to_decimal_ascii: signed 32-bit integer to decimal ascii characters
// input channel in_valid/in_stall/value, output channel out_valid/out_stall/
// character/last; each transaction out carries one character, most
// significant first, with last set on the final one; a negative number
// starts with '-', zero gives a single '0', no leading zeros
// numbers are converted one at a time; each passes through the load step,
// the 32 passes of the shift-and-add-3 bcd unit, a skip step for each of the
// z = 10 - n leading zeros (n is the digit count, 1 to 10), a final skip check,
// the sign step, a digit step for each of the n digits and the return step
// the minus sign goes out in the sign step, which every number passes through,
// so a negative number costs no more
// the first character is written to the output register in the sign step for
// a negative number and in the first digit step for a positive one
// the output register parts the two sides: the next number can be taken in the
// load step after the return step, even while the last character is stalled
// a stalled output holds its character and pauses the program at the next
// character; in_stall is high whenever the program is not at its load step
// reset clears the step counter and the output valid flag; nothing else is
// kept between numbers, and no clearing pass is needed
// depends on ita_pkg, ita_ucode_rom, ita_sequencer, ita_datapath
`default_nettype none

module int_to_decimal_ascii (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  signed [31:0] value,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [5:0]         character,
    output logic               last
);
    import ita_pkg::*;

    step_t      step;
    ctrl_word_t ctrl;
    status_t    status;

    // microcode program
    ita_ucode_rom u_rom (
        .step (step),
        .ctrl (ctrl)
    );

    // step counter and jumps
    ita_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .step   (step)
    );

    // bcd conversion and character output
    ita_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire
